>>> rtl/udasc_pkg.sv
package udasc_pkg;

   // Fixed field widths and character codes
   localparam int unsigned NIBBLE_W  = 4;
   localparam int unsigned CHAR_W    = 6;
   localparam int unsigned IN_W      = 64;
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
   localparam logic [NIBBLE_W-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [NIBBLE_W-1:0] DABBLE_ADD   = 4'd3;

   // Converter sequencer
   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CONV = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   // Digit emitter sequencer
   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_SKIP = 3'b010,
      B_EMIT = 3'b100
   } back_state_type;

   // Queue fill status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> rtl/udasc_front.sv
module udasc_front #(
   parameter int unsigned VALUE_WIDTH = 64,
   parameter int unsigned DIGITS      = 20
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [VALUE_WIDTH-1:0]          value,
   input  udasc_pkg::q_status_type         q_status,
   output logic                            push,
   output logic [DIGITS*udasc_pkg::NIBBLE_W-1:0] push_bcd
);

   localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);
   localparam int unsigned BCD_W = DIGITS * udasc_pkg::NIBBLE_W;

   udasc_pkg::front_state_type state_ff, state_in;
   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   // Add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*udasc_pkg::NIBBLE_W +: udasc_pkg::NIBBLE_W] >= udasc_pkg::DABBLE_LIMIT) begin
            bcd_adj[i*udasc_pkg::NIBBLE_W +: udasc_pkg::NIBBLE_W] =
               bcd_ff[i*udasc_pkg::NIBBLE_W +: udasc_pkg::NIBBLE_W] + udasc_pkg::DABBLE_ADD;
         end else begin
            bcd_adj[i*udasc_pkg::NIBBLE_W +: udasc_pkg::NIBBLE_W] =
               bcd_ff[i*udasc_pkg::NIBBLE_W +: udasc_pkg::NIBBLE_W];
         end
      end
   end

   // Sequence: take a beat, shift one bit a cycle, hand the digits on
   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      push     = 1'b0;
      unique case (state_ff)
         udasc_pkg::F_IDLE: begin
            if (start) begin
               bin_in   = value;
               bcd_in   = '0;
               cnt_in   = CNT_W'(VALUE_WIDTH);
               state_in = udasc_pkg::F_CONV;
            end
         end
         udasc_pkg::F_CONV: begin
            bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_WIDTH-1]};
            bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = udasc_pkg::F_PUSH;
            end
         end
         udasc_pkg::F_PUSH: begin
            if (!q_status.full) begin
               push     = 1'b1;
               state_in = udasc_pkg::F_IDLE;
            end
         end
         default: state_in = udasc_pkg::F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= udasc_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   assign busy     = (state_ff != udasc_pkg::F_IDLE);
   assign push_bcd = bcd_ff;

   // Busy drops only when the finished digits have gone into the queue
   a_busy_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(push))
      else $error("converter released without handing on its digits");

   // Never push into a full queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("converter pushed into a full queue");

endmodule

>>> rtl/udasc_queue.sv
module udasc_queue #(
   parameter int unsigned WIDTH = 80
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        push_data,
   input  logic                    pop,
   output logic [WIDTH-1:0]        pop_data,
   output udasc_pkg::q_status_type status
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;

   // Write the tail, advance pointers and the fill count
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

   // Never pop an empty queue
   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue popped while empty");

   // Pointers differ exactly when one entry is held
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff != rd_ptr_ff) == (count_ff == 2'd1))
      else $error("queue pointers disagree with fill count");

endmodule

>>> rtl/udasc_back.sv
module udasc_back #(
   parameter int unsigned DIGITS = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  udasc_pkg::q_status_type               q_status,
   input  logic [DIGITS*udasc_pkg::NIBBLE_W-1:0] pop_bcd,
   output logic                                  pop,
   output logic                                  rsp_valid,
   output logic [udasc_pkg::CHAR_W-1:0]          rsp_digit_char,
   output logic                                  rsp_last
);

   localparam int unsigned BCD_W  = DIGITS * udasc_pkg::NIBBLE_W;
   localparam int unsigned LEFT_W = $clog2(DIGITS + 1);

   udasc_pkg::back_state_type state_ff, state_in;
   logic [BCD_W-1:0]                 bcd_ff, bcd_in;
   logic [LEFT_W-1:0]                left_ff, left_in;
   logic [udasc_pkg::NIBBLE_W-1:0]   top_digit;
   logic                             valid_ff, valid_in;
   logic [udasc_pkg::CHAR_W-1:0]     char_ff, char_in;
   logic                             last_ff, last_in;

   assign top_digit = bcd_ff[BCD_W-1 -: udasc_pkg::NIBBLE_W];

   // Load a word, drop leading zeros, then emit one digit a cycle
   always_comb begin
      state_in = state_ff;
      bcd_in   = bcd_ff;
      left_in  = left_ff;
      pop      = 1'b0;
      valid_in = 1'b0;
      char_in  = char_ff;
      last_in  = 1'b0;
      unique case (state_ff)
         udasc_pkg::B_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               bcd_in   = pop_bcd;
               left_in  = LEFT_W'(DIGITS);
               state_in = udasc_pkg::B_SKIP;
            end
         end
         udasc_pkg::B_SKIP: begin
            if (top_digit == '0 && left_ff != LEFT_W'(1)) begin
               bcd_in  = {bcd_ff[BCD_W-udasc_pkg::NIBBLE_W-1:0], {udasc_pkg::NIBBLE_W{1'b0}}};
               left_in = left_ff - LEFT_W'(1);
            end else begin
               state_in = udasc_pkg::B_EMIT;
            end
         end
         udasc_pkg::B_EMIT: begin
            valid_in = 1'b1;
            char_in  = udasc_pkg::ASCII_ZERO + udasc_pkg::CHAR_W'(top_digit);
            last_in  = (left_ff == LEFT_W'(1));
            bcd_in   = {bcd_ff[BCD_W-udasc_pkg::NIBBLE_W-1:0], {udasc_pkg::NIBBLE_W{1'b0}}};
            left_in  = left_ff - LEFT_W'(1);
            if (left_ff == LEFT_W'(1)) begin
               state_in = udasc_pkg::B_IDLE;
            end
         end
         default: state_in = udasc_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= udasc_pkg::B_IDLE;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
      bcd_ff  <= bcd_in;
      left_ff <= left_in;
      char_ff <= char_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last       = last_ff;

   // A run ends with a gap before the next one
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("digit run followed without a gap");

   // Every emitted character is a decimal digit
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_char >= udasc_pkg::ASCII_ZERO &&
                     rsp_digit_char <= udasc_pkg::ASCII_ZERO + udasc_pkg::CHAR_W'(9)))
      else $error("emitted character is not a decimal digit");

endmodule

>>> rtl/unsigned_to_decimal_ascii.sv
// Unsigned binary to decimal ASCII. A beat is taken when start is high and busy is low; the
// low VALUE_WIDTH bits of req_value are converted and sent out as decimal digits, most
// significant first, with no leading zeros (zero gives a single '0'), one digit per clock on
// rsp_valid with rsp_last on the final one. The receiver cannot stall: every strobed digit must
// be taken. A shift-and-add-three converter shifts each value in bit by bit, then hands its
// digits to a two-entry queue, waiting while the queue is full; busy stays high until the
// digits have gone into the queue, so a new value is taken only after that. The emitter behind
// the queue drops the leading zeros, then turns round and emits the digits in turn; while the
// queue holds room the converter works on the next value in parallel.
module unsigned_to_decimal_ascii #(
   parameter int unsigned VALUE_WIDTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [udasc_pkg::IN_W-1:0]        req_value,
   output logic                              rsp_valid,
   output logic [udasc_pkg::CHAR_W-1:0]      rsp_digit_char,
   output logic                              rsp_last
);

   localparam int unsigned DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int unsigned BCD_W  = DIGITS * udasc_pkg::NIBBLE_W;

   udasc_pkg::q_status_type q_status;
   logic                    push, pop;
   logic [BCD_W-1:0]        push_bcd, pop_bcd;

   // Convert binary to packed decimal
   udasc_front #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DIGITS      (DIGITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .value    (req_value[VALUE_WIDTH-1:0]),
      .q_status (q_status),
      .push     (push),
      .push_bcd (push_bcd)
   );

   // Hold finished words between the two sides
   udasc_queue #(
      .WIDTH (BCD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_bcd),
      .pop       (pop),
      .pop_data  (pop_bcd),
      .status    (q_status)
   );

   // Emit significant digits as characters
   udasc_back #(
      .DIGITS (DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .pop_bcd        (pop_bcd),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int unsigned VALUE_WIDTH  = 64;
   localparam int unsigned DIGIT_BASE   = 10;
   localparam int unsigned MAX_DIGITS   = 20;
   localparam int unsigned DRAIN_CYCLES = VALUE_WIDTH + MAX_DIGITS + 16;
   localparam int unsigned PHASE_ITEMS  = 120;

   typedef struct {
      logic [udasc_pkg::CHAR_W-1:0] digit_char;
      logic                         is_last;
   } digit_beat_type;

   typedef struct {
      logic [udasc_pkg::IN_W-1:0] value;
      string                      text;   // empty: take the digits from the predictor
   } conv_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic [udasc_pkg::IN_W-1:0]   req_value = '0;
   logic                         busy;
   logic                         rsp_valid;
   logic [udasc_pkg::CHAR_W-1:0] rsp_digit_char;
   logic                         rsp_last;

   digit_beat_type expected_digit_q[$];
   string          typed_text_q[$];
   int             mismatch_count = 0;
   int             values_taken   = 0;
   int             digits_checked = 0;
   int             long_values    = 0;
   int             sender_idle_pct = 0;

   unsigned_to_decimal_ascii #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   always #2 clock = ~clock;

   // Print one line per mismatch and count every one
   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Decimal digits of the masked value, most significant first
   function automatic void queue_decimal_digits(logic [udasc_pkg::IN_W-1:0] value);
      logic [udasc_pkg::IN_W-1:0] width_mask;
      logic [udasc_pkg::IN_W-1:0] rest;
      logic [3:0]                 low_first [MAX_DIGITS];
      int                         count;
      digit_beat_type             beat;
      width_mask = (VALUE_WIDTH >= udasc_pkg::IN_W) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
      rest  = value & width_mask;
      count = 0;
      do begin
         low_first[count] = 4'(rest % DIGIT_BASE);
         rest = rest / DIGIT_BASE;
         count++;
      end while (rest != 0 && count < MAX_DIGITS);
      if (count == MAX_DIGITS) long_values++;
      for (int k = 0; k < count; k++) begin
         beat.digit_char = udasc_pkg::CHAR_W'({2'b00, low_first[count-1-k]}) +
                           udasc_pkg::ASCII_ZERO;
         beat.is_last    = (k == count - 1);
         expected_digit_q.push_back(beat);
      end
   endfunction

   // Digits typed in by hand for the directed rows
   function automatic void queue_typed_digits(string text);
      byte            ch;
      digit_beat_type beat;
      if (text.len() == MAX_DIGITS) long_values++;
      for (int k = 0; k < text.len(); k++) begin
         ch = text.getc(k);
         beat.digit_char = ch[udasc_pkg::CHAR_W-1:0];
         beat.is_last    = (k == text.len() - 1);
         expected_digit_q.push_back(beat);
      end
   endfunction

   // Check the outgoing digit first, then record a newly taken value
   always @(posedge clock) begin
      string text;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (expected_digit_q.size() == 0) begin
               report_mismatch($sformatf("digit 0x%02h with nothing expected", rsp_digit_char));
            end else begin
               digits_checked++;
               if (rsp_digit_char !== expected_digit_q[0].digit_char)
                  report_mismatch($sformatf("digit_char got %0d, want %0d",
                                  rsp_digit_char, expected_digit_q[0].digit_char));
               if (rsp_last !== expected_digit_q[0].is_last)
                  report_mismatch($sformatf("last got %b, want %b",
                                  rsp_last, expected_digit_q[0].is_last));
               void'(expected_digit_q.pop_front());
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            values_taken++;
            text = (typed_text_q.size() > 0) ? typed_text_q.pop_front() : "";
            if (text.len() > 0) queue_typed_digits(text);
            else queue_decimal_digits(req_value);
         end
      end
   end

   // Offer one value and hold it until the block takes it
   task automatic send_value(logic [udasc_pkg::IN_W-1:0] value, string text);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct) gap++;
      if (sender_idle_pct > 0 && $urandom_range(0, 7) == 0) gap += $urandom_range(1, 120);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      typed_text_q.push_back(text);
      start     <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Spread values over every digit count, with extra weight near powers of ten
   function automatic logic [udasc_pkg::IN_W-1:0] random_value();
      logic [udasc_pkg::IN_W-1:0] v;
      int                         k;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: ;
         1: v = v >> $urandom_range(0, udasc_pkg::IN_W - 1);
         2: begin
            k = $urandom_range(0, MAX_DIGITS - 1);
            v = 64'd1;
            repeat (k) v = v * DIGIT_BASE;
            v = v + 64'($urandom_range(0, 2)) - 64'd1;
         end
         default: v = 64'($urandom_range(0, 1000));
      endcase
      return v;
   endfunction

   conv_row_type directed_rows[] = '{
      '{64'd0,                      "0"},
      '{64'd1,                      "1"},
      '{64'd9,                      "9"},
      '{64'd10,                     "10"},
      '{64'd99,                     "99"},
      '{64'd100,                    "100"},
      '{64'hFFFF_FFFF,              "4294967295"},
      '{64'h8000_0000_0000_0000,    "9223372036854775808"},
      '{64'd9999999999999999999,    "9999999999999999999"},
      '{64'd10000000000000000000,   "10000000000000000000"},
      '{64'hFFFF_FFFF_FFFF_FFFF,    "18446744073709551615"},
      '{64'hAAAA_AAAA_AAAA_AAAA,    ""},
      '{64'h5555_5555_5555_5555,    ""},
      '{64'h0123_4567_89AB_CDEF,    ""},
      '{64'd1000000007,             ""},
      '{64'd0,                      "0"},
      '{64'hFFFF_FFFF_FFFF_FFFE,    ""},
      '{64'd7,                      "7"}
   };

   // Stimulus: reset, directed rows back to back, then four random phases with varied sender idling
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) send_value(directed_rows[i].value, directed_rows[i].text);
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1:       sender_idle_pct = 82;
            3:       sender_idle_pct = 16;
            default: sender_idle_pct = 0;
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) send_value(random_value(), "");
      end
      start <= 1'b0;
      while (expected_digit_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Converted %0d values (%0d of twenty digits), checked %0d digit beats.",
               values_taken, long_values, digits_checked);
      $display("Mismatches: %0d", mismatch_count);
      if (mismatch_count == 0 && expected_digit_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Give up after a generous fixed time
   initial begin
      #5ms;
      $display("Timeout with %0d digits still outstanding", expected_digit_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
